// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define PCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// clocked check that also holds across reset
`define PCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;

   localparam int WINDOWS = 7;

   localparam logic [63:0] IO_SPACE_BASE  = 64'h0000_0801_fc00_0000;
   localparam logic [63:0] MEM_SPACE_BASE = 64'h0000_0800_0000_0000;
   localparam int          BUS_SHIFT      = 33;

   localparam logic [5:0] COMMAND_WORD   = 6'h01;
   localparam logic [5:0] BAR_FIRST_WORD = 6'h04;
   localparam logic [5:0] BAR_LAST_WORD  = 6'h09;
   localparam logic [5:0] ROM_WORD       = 6'h0c;
   localparam logic [5:0] IRQ_WORD       = 6'h0f;

   localparam logic [2:0] ROM_WINDOW    = 3'd6;
   localparam logic [7:0] LINE_DISABLED = 8'hff;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_64 = 2'd3;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_READ  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_CHECK = 3'd3,
      CMD_IRQ   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORD0,
      ST_WORD1,
      ST_EXTRA
   } state_type;

   typedef struct packed {
      logic        event_hit;
      logic [2:0]  number;
      logic        is_io;
      logic [63:0] base;
      logic [31:0] length;
   } bar_rec_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] read_data;
      logic        allowed;
      logic        bar_event;
      logic [2:0]  bar_number;
      logic        bar_is_io;
      logic [63:0] bar_system_base;
      logic [31:0] bar_length;
      logic        irq_valid;
      logic [7:0]  irq_line;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/pci_config_space_with_bar_decode_core.sv =====
// PCI configuration space for several functions, each word held with its write mask.
// Requests: drive start with the req_ fields while busy is low; the request is taken
// at that clock edge. Commands are load word, config read, config write, window
// access check and interrupt.
// Results: rsp_valid is high for exactly one cycle per result; rsp_last marks the
// final result of a request. The receiver cannot stall, results are never held.
// Timing: all words and masks sit in one memory with a registered read port, one
// word is read and written back per cycle. A request of 8, 16 or 32 bits is read
// into that register, handled in WORD0 and its result registered; the next request
// can be taken as that result shows. A 64-bit read or write walks two words, in
// WORD1 too; a write mapping two windows gives its second result in the cycle after.
// The bus number register is written through csr_valid/csr_ready, always ready,
// and must only be written while the block is idle.
// Reset clears the sequencer, the result strobe, the bus number and the per-window
// io flags. Words and masks are not cleared and must be loaded before use.
module pci_config_space_with_bar_decode_core #(
   parameter int FUNCTIONS          = 8,
   parameter int WORDS_PER_FUNCTION = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_function_number,
   input  logic [7:0]  req_byte_address,
   input  logic [1:0]  req_size_code,
   input  logic [63:0] req_write_data,
   input  logic [31:0] req_load_mask,
   input  logic [2:0]  req_window,
   input  logic        req_asserted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_data,
   output logic        rsp_allowed,
   output logic        rsp_bar_event,
   output logic [2:0]  rsp_bar_number,
   output logic        rsp_bar_is_io,
   output logic [63:0] rsp_bar_system_base,
   output logic [31:0] rsp_bar_length,
   output logic        rsp_irq_valid,
   output logic [7:0]  rsp_irq_line,
   output logic        rsp_last
);

`include "assert_macros.svh"

   localparam int DEPTH  = FUNCTIONS * WORDS_PER_FUNCTION;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FLAG_N = FUNCTIONS * pcs_pkg::WINDOWS;
   localparam int FLAG_W = $clog2(FLAG_N);

   function automatic logic [5:0] word_index(input logic [2:0] cmd, input logic [7:0] a,
                                             input logic [1:0] sz);
      logic [5:0] w;
      case (cmd)
         pcs_pkg::CMD_READ, pcs_pkg::CMD_WRITE: begin
            w = (sz == pcs_pkg::SIZE_64) ? {a[7:3], 1'b0} : a[7:2];
         end
         pcs_pkg::CMD_CHECK: begin
            w = pcs_pkg::COMMAND_WORD;
         end
         pcs_pkg::CMD_IRQ: begin
            w = pcs_pkg::IRQ_WORD;
         end
         default: begin
            w = a[7:2];
         end
      endcase
      return w;
   endfunction

   function automatic logic word_ok(input logic [2:0] f, input logic [5:0] w);
      return (32'(f) < FUNCTIONS) && (32'(w) < WORDS_PER_FUNCTION);
   endfunction

   function automatic logic [ADDR_W-1:0] word_addr(input logic [2:0] f, input logic [5:0] w);
      return ADDR_W'(ADDR_W'(f) * ADDR_W'(WORDS_PER_FUNCTION) + ADDR_W'(w));
   endfunction

   function automatic pcs_pkg::rsp_type rsp_from_rec(input pcs_pkg::bar_rec_type rec,
                                                     input logic last);
      pcs_pkg::rsp_type r;
      r                 = '0;
      r.valid           = 1'b1;
      r.bar_event       = rec.event_hit;
      r.bar_number      = rec.number;
      r.bar_is_io       = rec.is_io;
      r.bar_system_base = rec.base;
      r.bar_length      = rec.length;
      r.last            = last;
      return r;
   endfunction

   pcs_pkg::state_type   state_ff, state_in;
   logic [2:0]           cmd_ff, func_ff, win_ff;
   logic [7:0]           addr_ff;
   logic [1:0]           size_ff;
   logic [63:0]          wdata_ff;
   logic [31:0]          lmask_ff;
   logic [31:0]          lo_ff, lo_in;
   pcs_pkg::bar_rec_type rec0_ff, rec0_in, rec1_ff, rec1_in;
   pcs_pkg::rsp_type     rsp_ff, rsp_in;
   logic [7:0]           bus_ff;
   logic [FLAG_N-1:0]    io_flags_ff, io_flags_in;

   logic                 accept;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [63:0]          ram_wdata, ram_rdata;

   logic [5:0]           idx_w0, idx_w1, idx_cur;
   logic                 ok_cur;
   logic [ADDR_W-1:0]    cur_addr;
   logic [31:0]          rd_word;
   logic [63:0]          rd_sub;
   logic [31:0]          lane, lane_data;
   logic [31:0]          dec_word;
   pcs_pkg::bar_rec_type dec_rec, cur_g;
   logic                 flag_we;
   logic                 chk_ok, chk_io, chk_allowed;
   logic [7:0]           line;
   logic                 line_ok;

   assign accept    = start && !busy;
   assign busy      = (state_ff != pcs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   pcs_ram #(
      .WIDTH(64),
      .DEPTH(DEPTH)
   ) u_words (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign idx_w0   = word_index(cmd_ff, addr_ff, size_ff);
   assign idx_w1   = {addr_ff[7:3], 1'b1};
   assign idx_cur  = (state_ff == pcs_pkg::ST_WORD1) ? idx_w1 : idx_w0;
   assign ok_cur   = word_ok(func_ff, idx_cur);
   assign cur_addr = word_addr(func_ff, idx_cur);
   assign rd_word  = ok_cur ? ram_rdata[31:0] : 32'b0;

   always_comb begin
      case (size_ff)
         pcs_pkg::SIZE_8: begin
            rd_sub = {56'b0, rd_word[{addr_ff[1:0], 3'b0} +: 8]};
         end
         pcs_pkg::SIZE_16: begin
            rd_sub = {48'b0, rd_word[{addr_ff[1], 4'b0} +: 16]};
         end
         default: begin
            rd_sub = {32'b0, rd_word};
         end
      endcase
   end

   always_comb begin
      if (state_ff == pcs_pkg::ST_WORD1) begin
         lane      = '1;
         lane_data = wdata_ff[63:32];
      end else begin
         case (size_ff)
            pcs_pkg::SIZE_8: begin
               lane      = 32'hff << {addr_ff[1:0], 3'b0};
               lane_data = {24'b0, wdata_ff[7:0]} << {addr_ff[1:0], 3'b0};
            end
            pcs_pkg::SIZE_16: begin
               lane      = 32'hffff << {addr_ff[1], 4'b0};
               lane_data = {16'b0, wdata_ff[15:0]} << {addr_ff[1], 4'b0};
            end
            default: begin
               lane      = '1;
               lane_data = wdata_ff[31:0];
            end
         endcase
      end
   end

   pcs_bar_decode u_decode (
      .word      (ram_rdata[31:0]),
      .mask      (ram_rdata[63:32]),
      .lane      (lane),
      .data      (lane_data),
      .word_index(idx_cur),
      .bus_number(bus_ff),
      .new_word  (dec_word),
      .rec       (dec_rec)
   );

   assign cur_g = ok_cur ? dec_rec : '0;

   assign chk_ok      = (32'(func_ff) < FUNCTIONS) && (32'(win_ff) < pcs_pkg::WINDOWS);
   assign chk_io      = chk_ok ? io_flags_ff[FLAG_W'(FLAG_W'(func_ff) * FLAG_W'(pcs_pkg::WINDOWS)
                                             + FLAG_W'(win_ff))] : 1'b0;
   assign chk_allowed = chk_ok && (chk_io ? rd_word[0] : rd_word[1]);

   assign line    = rd_word[7:0];
   assign line_ok = ok_cur && (line != pcs_pkg::LINE_DISABLED);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcs_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pcs_pkg::ST_WORD0;
            end
         end
         pcs_pkg::ST_WORD0: begin
            if ((cmd_ff == pcs_pkg::CMD_READ || cmd_ff == pcs_pkg::CMD_WRITE) &&
                size_ff == pcs_pkg::SIZE_64) begin
               state_in = pcs_pkg::ST_WORD1;
            end else begin
               state_in = pcs_pkg::ST_IDLE;
            end
         end
         pcs_pkg::ST_WORD1: begin
            if (cmd_ff == pcs_pkg::CMD_WRITE && rec0_ff.event_hit && cur_g.event_hit) begin
               state_in = pcs_pkg::ST_EXTRA;
            end else begin
               state_in = pcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcs_pkg::ST_IDLE;
         end
      endcase
   end

   // memory access and results
   always_comb begin
      ram_raddr = word_addr(req_function_number,
                            word_index(req_command, req_byte_address, req_size_code));
      ram_we    = 1'b0;
      ram_waddr = cur_addr;
      ram_wdata = {ram_rdata[63:32], dec_word};
      rsp_in    = '0;
      rec0_in   = rec0_ff;
      rec1_in   = rec1_ff;
      lo_in     = lo_ff;
      flag_we   = 1'b0;
      case (state_ff)
         pcs_pkg::ST_WORD0: begin
            ram_raddr = word_addr(func_ff, idx_w1);
            case (cmd_ff)
               pcs_pkg::CMD_LOAD: begin
                  ram_we      = ok_cur;
                  ram_wdata   = {lmask_ff, wdata_ff[31:0]};
                  rsp_in.valid = 1'b1;
                  rsp_in.last  = 1'b1;
               end
               pcs_pkg::CMD_READ: begin
                  if (size_ff == pcs_pkg::SIZE_64) begin
                     lo_in = rd_word;
                  end else begin
                     rsp_in.valid     = 1'b1;
                     rsp_in.read_data = rd_sub;
                     rsp_in.last      = 1'b1;
                  end
               end
               pcs_pkg::CMD_WRITE: begin
                  ram_we  = ok_cur;
                  flag_we = cur_g.event_hit;
                  if (size_ff == pcs_pkg::SIZE_64) begin
                     rec0_in = cur_g;
                  end else begin
                     rsp_in = rsp_from_rec(cur_g, 1'b1);
                  end
               end
               pcs_pkg::CMD_CHECK: begin
                  rsp_in.valid   = 1'b1;
                  rsp_in.allowed = chk_allowed;
                  rsp_in.last    = 1'b1;
               end
               pcs_pkg::CMD_IRQ: begin
                  rsp_in.valid     = 1'b1;
                  rsp_in.irq_valid = line_ok;
                  rsp_in.irq_line  = line_ok ? line : 8'b0;
                  rsp_in.last      = 1'b1;
               end
               default: begin
                  rsp_in.valid = 1'b1;
                  rsp_in.last  = 1'b1;
               end
            endcase
         end
         pcs_pkg::ST_WORD1: begin
            case (cmd_ff)
               pcs_pkg::CMD_READ: begin
                  rsp_in.valid     = 1'b1;
                  rsp_in.read_data = {rd_word, lo_ff};
                  rsp_in.last      = 1'b1;
               end
               pcs_pkg::CMD_WRITE: begin
                  ram_we  = ok_cur;
                  flag_we = cur_g.event_hit;
                  if (rec0_ff.event_hit && cur_g.event_hit) begin
                     rsp_in  = rsp_from_rec(rec0_ff, 1'b0);
                     rec1_in = cur_g;
                  end else begin
                     rsp_in = rsp_from_rec(rec0_ff.event_hit ? rec0_ff : cur_g, 1'b1);
                  end
               end
               default: begin
                  rsp_in.valid = 1'b1;
                  rsp_in.last  = 1'b1;
               end
            endcase
         end
         pcs_pkg::ST_EXTRA: begin
            rsp_in = rsp_from_rec(rec1_ff, 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      io_flags_in = io_flags_ff;
      if (flag_we) begin
         io_flags_in[FLAG_W'(FLAG_W'(func_ff) * FLAG_W'(pcs_pkg::WINDOWS)
                             + FLAG_W'(cur_g.number))] = cur_g.is_io;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcs_pkg::ST_IDLE;
         rsp_ff.valid <= 1'b0;
         bus_ff       <= 8'b0;
         io_flags_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
         io_flags_ff  <= io_flags_in;
         if (csr_valid && csr_ready) begin
            bus_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         func_ff  <= req_function_number;
         addr_ff  <= req_byte_address;
         size_ff  <= req_size_code;
         wdata_ff <= req_write_data;
         lmask_ff <= req_load_mask;
         win_ff   <= req_window;
      end
      lo_ff                  <= lo_in;
      rec0_ff                <= rec0_in;
      rec1_ff                <= rec1_in;
      rsp_ff.read_data       <= rsp_in.read_data;
      rsp_ff.allowed         <= rsp_in.allowed;
      rsp_ff.bar_event       <= rsp_in.bar_event;
      rsp_ff.bar_number      <= rsp_in.bar_number;
      rsp_ff.bar_is_io       <= rsp_in.bar_is_io;
      rsp_ff.bar_system_base <= rsp_in.bar_system_base;
      rsp_ff.bar_length      <= rsp_in.bar_length;
      rsp_ff.irq_valid       <= rsp_in.irq_valid;
      rsp_ff.irq_line        <= rsp_in.irq_line;
      rsp_ff.last            <= rsp_in.last;
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_allowed         = rsp_ff.allowed;
   assign rsp_bar_event       = rsp_ff.bar_event;
   assign rsp_bar_number      = rsp_ff.bar_number;
   assign rsp_bar_is_io       = rsp_ff.bar_is_io;
   assign rsp_bar_system_base = rsp_ff.bar_system_base;
   assign rsp_bar_length      = rsp_ff.bar_length;
   assign rsp_irq_valid       = rsp_ff.irq_valid;
   assign rsp_irq_line        = rsp_ff.irq_line;
   assign rsp_last            = rsp_ff.last;

   `PCS_ASSERT(a_second_follows, clock, reset, rsp_valid && !rsp_last |=> rsp_valid && rsp_last)
   `PCS_ASSERT(a_last_frees, clock, reset, rsp_valid && rsp_last |-> !busy)
   `PCS_ASSERT(a_accept_quiet, clock, reset, start && !busy |=> busy && !rsp_valid)
   `PCS_ASSERT(a_event_window, clock, reset, rsp_valid && rsp_bar_event |-> rsp_bar_number <= pcs_pkg::ROM_WINDOW)
   `PCS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid)

endmodule

// ===== rtl/pcs_ram.sv =====
module pcs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pcs_bar_decode.sv =====
module pcs_bar_decode (
   input  logic [31:0]         word,
   input  logic [31:0]         mask,
   input  logic [31:0]         lane,
   input  logic [31:0]         data,
   input  logic [5:0]          word_index,
   input  logic [7:0]          bus_number,
   output logic [31:0]         new_word,
   output pcs_pkg::bar_rec_type rec
);

   logic [31:0] data_masked;
   logic        full;
   logic        bar_word;
   logic        rom;
   logic [2:0]  number;
   logic        is_io;
   logic        mapped;
   logic [63:0] space_base;
   logic [63:0] bus_offset;
   logic [31:0] bar_base;

   assign data_masked = data & mask;
   assign full        = (lane == '1);
   assign new_word    = (word & ~(mask & lane)) | (data & mask & lane);
   assign rom         = (word_index == pcs_pkg::ROM_WORD);
   assign bar_word    = rom || ((word_index >= pcs_pkg::BAR_FIRST_WORD) &&
                                (word_index <= pcs_pkg::BAR_LAST_WORD));
   assign number      = rom ? pcs_pkg::ROM_WINDOW
                            : 3'(word_index - pcs_pkg::BAR_FIRST_WORD);
   assign is_io       = new_word[0] && !rom;
   assign mapped      = full && bar_word && (data_masked != mask) && (data_masked != '0) &&
                        (!rom || new_word[0]);

   assign space_base  = is_io ? pcs_pkg::IO_SPACE_BASE : pcs_pkg::MEM_SPACE_BASE;
   assign bus_offset  = 64'(bus_number) << pcs_pkg::BUS_SHIFT;
   assign bar_base    = is_io ? (new_word & ~32'h3) : (new_word & ~32'hf);

   always_comb begin
      rec = '0;
      if (mapped) begin
         rec.event_hit = 1'b1;
         rec.number    = number;
         rec.is_io     = is_io;
         rec.base      = space_base + bus_offset + {32'b0, bar_base};
         rec.length    = (~mask | 32'd1) + 32'd1;
      end
   end

endmodule

// ===== sim/tb_pci_config_space_with_bar_decode_core.sv =====
module tb_pci_config_space_with_bar_decode_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pcs_pkg::*;

   localparam int          FUNCS      = 8;
   localparam int          WORDS      = 64;
   localparam int          WIN_COUNT  = 7;
   localparam logic [63:0] IO_WIN_BASE  = 64'h0000_0801_fc00_0000;
   localparam logic [63:0] MEM_WIN_BASE = 64'h0000_0800_0000_0000;
   localparam logic [1:0]  SIZE_32    = 2'd2;
   localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
   localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
   localparam logic [2:0]  WINDOW_NONE  = 3'd7;
   localparam int          CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [2:0]  cmd;
      logic [2:0]  fn;
      logic [7:0]  addr;
      logic [1:0]  size;
      logic [63:0] wdata;
      logic [31:0] lmask;
      logic [2:0]  win;
      logic        asrt;
   } cfg_req_t;

   typedef struct {
      logic [63:0] read_data;
      logic        allowed;
      logic        bar_event;
      logic [2:0]  bar_number;
      logic        bar_is_io;
      logic [63:0] bar_system_base;
      logic [31:0] bar_length;
      logic        irq_valid;
      logic [7:0]  irq_line;
      logic        last;
   } cfg_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [2:0]  req_function_number = '0;
   logic [7:0]  req_byte_address = '0;
   logic [1:0]  req_size_code = '0;
   logic [63:0] req_write_data = '0;
   logic [31:0] req_load_mask = '0;
   logic [2:0]  req_window = '0;
   logic        req_asserted = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_write_data = '0;
   logic        rsp_valid;
   logic [63:0] rsp_read_data;
   logic        rsp_allowed;
   logic        rsp_bar_event;
   logic [2:0]  rsp_bar_number;
   logic        rsp_bar_is_io;
   logic [63:0] rsp_bar_system_base;
   logic [31:0] rsp_bar_length;
   logic        rsp_irq_valid;
   logic [7:0]  rsp_irq_line;
   logic        rsp_last;

   // shadow copy of the configuration space
   logic [31:0] shadow_word [FUNCS*WORDS];
   logic [31:0] shadow_mask [FUNCS*WORDS];
   logic        shadow_io   [FUNCS*WIN_COUNT];
   logic [7:0]  shadow_bus;

   cfg_rsp_t awaited_rsp [$];
   cfg_rsp_t want_rsp;
   int       err_count = 0;
   int       cycle_count = 0;
   bit       no_gap_run = 1'b0;

   pci_config_space_with_bar_decode_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_function_number(req_function_number),
      .req_byte_address(req_byte_address),
      .req_size_code(req_size_code),
      .req_write_data(req_write_data),
      .req_load_mask(req_load_mask),
      .req_window(req_window),
      .req_asserted(req_asserted),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_allowed(rsp_allowed),
      .rsp_bar_event(rsp_bar_event),
      .rsp_bar_number(rsp_bar_number),
      .rsp_bar_is_io(rsp_bar_is_io),
      .rsp_bar_system_base(rsp_bar_system_base),
      .rsp_bar_length(rsp_bar_length),
      .rsp_irq_valid(rsp_irq_valid),
      .rsp_irq_line(rsp_irq_line),
      .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[pci_config_space_with_bar_decode_core] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      if (err_count < 200)
         $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
      err_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
         input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("result with nothing awaited", rsp_read_data, 64'd0);
         end else begin
            want_rsp = awaited_rsp.pop_front();
            check_field("read_data", rsp_read_data, want_rsp.read_data);
            check_field("allowed", rsp_allowed, want_rsp.allowed);
            check_field("bar_event", rsp_bar_event, want_rsp.bar_event);
            check_field("bar_number", rsp_bar_number, want_rsp.bar_number);
            check_field("bar_is_io", rsp_bar_is_io, want_rsp.bar_is_io);
            check_field("bar_system_base", rsp_bar_system_base, want_rsp.bar_system_base);
            check_field("bar_length", rsp_bar_length, want_rsp.bar_length);
            check_field("irq_valid", rsp_irq_valid, want_rsp.irq_valid);
            check_field("irq_line", rsp_irq_line, want_rsp.irq_line);
            check_field("last", rsp_last, want_rsp.last);
         end
      end
   end

   // masked write of one word, returns 1 when a window gets mapped
   function automatic bit write_shadow_word(input int f, input int w, input logic [31:0] lane,
         input logic [31:0] d, inout cfg_rsp_t rec);
      int          idx;
      logic [31:0] m;
      logic [31:0] nv;
      logic [31:0] dm;
      logic [2:0]  bar;
      logic        is_io;
      logic [63:0] stride;
      logic [63:0] base;
      idx = f * WORDS + w;
      m = shadow_mask[idx];
      nv = (shadow_word[idx] & ~(m & lane)) | (d & m & lane);
      shadow_word[idx] = nv;
      if (lane != 32'hffff_ffff)
         return 1'b0;
      dm = d & m;
      if (dm == m || dm == 32'd0)
         return 1'b0;
      if (w >= BAR_FIRST_WORD && w <= BAR_LAST_WORD)
         bar = w - BAR_FIRST_WORD;
      else if (w == ROM_WORD)
         bar = ROM_WINDOW;
      else
         return 1'b0;
      stride = {56'd0, shadow_bus};
      stride = stride << 33;
      if (nv[0] && bar != ROM_WINDOW) begin
         is_io = 1'b1;
         base = IO_WIN_BASE + stride + {32'd0, nv & 32'hffff_fffc};
      end else if (nv[0] || bar != ROM_WINDOW) begin
         is_io = 1'b0;
         base = MEM_WIN_BASE + stride + {32'd0, nv & 32'hffff_fff0};
      end else begin
         return 1'b0;
      end
      shadow_io[f * WIN_COUNT + bar] = is_io;
      rec.bar_event = 1'b1;
      rec.bar_number = bar;
      rec.bar_is_io = is_io;
      rec.bar_system_base = base;
      rec.bar_length = (~m | 32'd1) + 32'd1;
      return 1'b1;
   endfunction

   function automatic void predict_config_access(input cfg_req_t r);
      cfg_rsp_t    res0;
      cfg_rsp_t    res1;
      int          f;
      int          w;
      int          w0;
      int          sh;
      bit          hit0;
      bit          hit1;
      logic [31:0] word;
      res0 = '{default: '0};
      res1 = '{default: '0};
      hit0 = 1'b0;
      hit1 = 1'b0;
      f = r.fn;
      w = r.addr >> 2;
      w0 = (r.addr >> 3) * 2;
      case (r.cmd)
         CMD_LOAD: begin
            shadow_word[f * WORDS + w] = r.wdata[31:0];
            shadow_mask[f * WORDS + w] = r.lmask;
         end
         CMD_READ: begin
            word = shadow_word[f * WORDS + w];
            case (r.size)
               SIZE_8:  res0.read_data = {56'd0, word[8 * r.addr[1:0] +: 8]};
               SIZE_16: res0.read_data = {48'd0, word[16 * r.addr[1] +: 16]};
               SIZE_32: res0.read_data = {32'd0, word};
               default: res0.read_data = {shadow_word[f * WORDS + w0 + 1],
                                          shadow_word[f * WORDS + w0]};
            endcase
         end
         CMD_WRITE: begin
            case (r.size)
               SIZE_8: begin
                  sh = 8 * r.addr[1:0];
                  hit0 = write_shadow_word(f, w, 32'hff << sh, {24'd0, r.wdata[7:0]} << sh,
                                           res0);
               end
               SIZE_16: begin
                  sh = 16 * r.addr[1];
                  hit0 = write_shadow_word(f, w, 32'hffff << sh, {16'd0, r.wdata[15:0]} << sh,
                                           res0);
               end
               SIZE_32: begin
                  hit0 = write_shadow_word(f, w, 32'hffff_ffff, r.wdata[31:0], res0);
               end
               default: begin
                  hit0 = write_shadow_word(f, w0, 32'hffff_ffff, r.wdata[31:0], res0);
                  if (hit0)
                     hit1 = write_shadow_word(f, w0 + 1, 32'hffff_ffff, r.wdata[63:32], res1);
                  else
                     hit1 = write_shadow_word(f, w0 + 1, 32'hffff_ffff, r.wdata[63:32], res0);
               end
            endcase
         end
         CMD_CHECK: begin
            if (r.win != WINDOW_NONE) begin
               word = shadow_word[f * WORDS + COMMAND_WORD];
               res0.allowed = shadow_io[f * WIN_COUNT + r.win] ? word[0] : word[1];
            end
         end
         CMD_IRQ: begin
            word = shadow_word[f * WORDS + IRQ_WORD];
            if (word[7:0] != LINE_DISABLED) begin
               res0.irq_valid = 1'b1;
               res0.irq_line = word[7:0];
            end
         end
         default: ;
      endcase
      if (hit0 && hit1) begin
         res1.last = 1'b1;
         awaited_rsp.push_back(res0);
         awaited_rsp.push_back(res1);
      end else begin
         res0.last = 1'b1;
         awaited_rsp.push_back(res0);
      end
   endfunction

   function automatic cfg_req_t make_req(input logic [2:0] cmd, input int f, input int a,
         input logic [1:0] size, input logic [63:0] wd, input logic [31:0] lm,
         input logic [2:0] win);
      cfg_req_t r;
      r.cmd = cmd;
      r.fn = f;
      r.addr = a;
      r.size = size;
      r.wdata = wd;
      r.lmask = lm;
      r.win = win;
      r.asrt = $urandom_range(0, 1);
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the request was taken
   task automatic send_request(input cfg_req_t r);
      int gap;
      if ($urandom_range(0, 31) == 0)
         no_gap_run = !no_gap_run;
      gap = no_gap_run ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         start = 1'b0;
         req_command = $urandom;
         req_function_number = $urandom;
         req_byte_address = $urandom;
         req_size_code = $urandom;
         req_write_data = {$urandom, $urandom};
         req_load_mask = $urandom;
         req_window = $urandom;
         req_asserted = $urandom;
         @(negedge clock);
      end
      start = 1'b1;
      req_command = r.cmd;
      req_function_number = r.fn;
      req_byte_address = r.addr;
      req_size_code = r.size;
      req_write_data = r.wdata;
      req_load_mask = r.lmask;
      req_window = r.win;
      req_asserted = r.asrt;
      do @(posedge clock); while (busy);
      predict_config_access(r);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      start = 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_bus_number(input logic [7:0] value);
      drain_responses();
      csr_valid = 1'b1;
      csr_write_data = value;
      do @(posedge clock); while (!csr_ready);
      shadow_bus = value;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_write_data = $urandom;
   endtask

   function automatic cfg_req_t random_request();
      cfg_req_t r;
      int       p;
      int       w;
      r = make_req(CMD_READ, $urandom_range(0, FUNCS - 1), 0, $urandom_range(0, 3),
                   {$urandom, $urandom}, $urandom, $urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0:       w = COMMAND_WORD;
            1:       w = $urandom_range(BAR_FIRST_WORD, BAR_LAST_WORD);
            2:       w = ROM_WORD;
            default: w = IRQ_WORD;
         endcase
      end else begin
         w = $urandom_range(0, WORDS - 1);
      end
      r.addr = {w[5:0], 2'(($urandom))};
      p = $urandom_range(0, 99);
      if (p < 12) begin
         r.cmd = CMD_LOAD;
         case ($urandom_range(0, 4))
            0:       r.lmask = 32'hffff_ffff << $urandom_range(0, 31);
            1:       r.lmask = 32'hffff_ffff;
            2:       r.lmask = 32'd0;
            default: r.lmask = $urandom;
         endcase
         if (w == IRQ_WORD && $urandom_range(0, 2) == 0)
            r.wdata[7:0] = LINE_DISABLED;
      end else if (p < 40) begin
         r.cmd = CMD_WRITE;
         case ($urandom_range(0, 19))
            0, 1, 2:    r.size = SIZE_8;
            3, 4, 5:    r.size = SIZE_16;
            6, 7, 8, 9, 10, 11, 12, 13: r.size = SIZE_32;
            default:    r.size = SIZE_64;
         endcase
         case ($urandom_range(0, 9))
            0:       r.wdata = '1;
            1:       r.wdata = '0;
            default: ;
         endcase
      end else if (p < 65) begin
         r.cmd = CMD_READ;
      end else if (p < 80) begin
         r.cmd = CMD_CHECK;
      end else if (p < 92) begin
         r.cmd = CMD_IRQ;
      end else begin
         r.cmd = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
      end
      return r;
   endfunction

   // every word gets data and mask before anything reads it
   task automatic test_load_all_words();
      logic [31:0] data;
      logic [31:0] mask;
      for (int f = 0; f < FUNCS; f++) begin
         for (int w = 0; w < WORDS; w++) begin
            data = $urandom;
            case ($urandom_range(0, 3))
               0:       mask = 32'hffff_ffff << $urandom_range(0, 31);
               1:       mask = 32'hffff_ffff;
               default: mask = $urandom;
            endcase
            send_request(make_req(CMD_LOAD, f, {w[5:0], 2'(($urandom))}, $urandom,
                                  {$urandom, data}, mask, $urandom));
         end
      end
   endtask

   task automatic test_directed_cases();
      // io bar, then two windows mapped by one 64-bit write
      send_request(make_req(CMD_LOAD, 0, 8'h10, SIZE_32, 64'h1, 32'hffff_ff00, 0));
      send_request(make_req(CMD_WRITE, 0, 8'h10, SIZE_32, 64'h1234_5601, 0, 0));
      send_request(make_req(CMD_LOAD, 0, 8'h14, SIZE_32, 64'h0, 32'hfff0_0000, 0));
      send_request(make_req(CMD_WRITE, 0, 8'h10, SIZE_64, 64'hdead_0000_8765_4301, 0, 0));
      // data equal to the mask, zero data, partial write
      send_request(make_req(CMD_WRITE, 0, 8'h14, SIZE_32, '1, 0, 0));
      send_request(make_req(CMD_WRITE, 0, 8'h14, SIZE_32, '0, 0, 0));
      send_request(make_req(CMD_WRITE, 0, 8'h12, SIZE_16, 64'h0000_5a5a, 0, 0));
      // rom disabled, then enabled
      send_request(make_req(CMD_LOAD, 1, 8'h30, SIZE_32, 64'h0, 32'hffff_f801, 0));
      send_request(make_req(CMD_WRITE, 1, 8'h30, SIZE_32, 64'habcd_e000, 0, 0));
      send_request(make_req(CMD_WRITE, 1, 8'h30, SIZE_32, 64'habcd_e001, 0, 0));
      // access checks against the command register
      send_request(make_req(CMD_LOAD, 0, 8'h04, SIZE_32, 64'h1, 32'h0000_ffff, 0));
      send_request(make_req(CMD_CHECK, 0, 8'h00, SIZE_8, 64'h0, 0, 0));
      send_request(make_req(CMD_CHECK, 0, 8'h00, SIZE_8, 64'h0, 0, 1));
      send_request(make_req(CMD_CHECK, 0, 8'h00, SIZE_8, 64'h0, 0, WINDOW_NONE));
      // interrupt line disabled, then set
      send_request(make_req(CMD_LOAD, 2, 8'h3c, SIZE_32, {56'd0, LINE_DISABLED}, 32'hff, 0));
      send_request(make_req(CMD_IRQ, 2, 8'h00, SIZE_8, 64'h0, 0, 0));
      send_request(make_req(CMD_WRITE, 2, 8'h3c, SIZE_8, 64'h0b, 0, 0));
      send_request(make_req(CMD_IRQ, 2, 8'h00, SIZE_8, 64'h0, 0, 0));
      // reads, and a 64-bit write, at the address extremes
      send_request(make_req(CMD_READ, 7, 8'hff, SIZE_8, '1, '1, 7));
      send_request(make_req(CMD_READ, 7, 8'hff, SIZE_16, '0, '0, 0));
      send_request(make_req(CMD_READ, 7, 8'hff, SIZE_32, '0, '0, 0));
      send_request(make_req(CMD_READ, 0, 8'h00, SIZE_64, '0, '0, 0));
      send_request(make_req(CMD_WRITE, 7, 8'hff, SIZE_64, '1, '1, 0));
      send_request(make_req(CMD_READ, 7, 8'hf8, SIZE_64, '0, '0, 0));
      // commands without a meaning
      send_request(make_req(CMD_SPARE_LO, 3, 8'h40, SIZE_32, '1, '1, 3));
      send_request(make_req(CMD_SPARE_HI, 4, 8'h80, SIZE_64, '1, '1, 5));
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count)
         send_request(random_request());
   endtask

   task automatic test_bus_number_settings();
      set_bus_number(8'hff);
      test_random_traffic(250);
      set_bus_number(8'h00);
      test_random_traffic(250);
      set_bus_number($urandom_range(1, 254));
      test_random_traffic(250);
      set_bus_number(8'h01);
      test_random_traffic(250);
   endtask

   initial begin
      shadow_bus = 8'h00;
      for (int i = 0; i < FUNCS * WIN_COUNT; i++)
         shadow_io[i] = 1'b0;
      for (int i = 0; i < FUNCS * WORDS; i++) begin
         shadow_word[i] = '0;
         shadow_mask[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_all_words();
      test_directed_cases();
      test_random_traffic(250);
      test_bus_number_settings();
      drain_responses();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("[pci_config_space_with_bar_decode_core] OK");
      end else begin
         $display("[pci_config_space_with_bar_decode_core] ERROR");
      end
      $finish;
   end

endmodule
